>>> sv/iec958sf_pkg.sv
// Shared types and constants for the IEC 60958 subframe formatter.
package iec958sf_pkg;

    localparam int unsigned BLOCK_FRAMES = 192;
    localparam int unsigned MIN_CHANNELS = 2;
    localparam int unsigned CHAN_LIMIT   = 8;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned FRAME_W    = 8;
    localparam int unsigned CHAN_W     = 3;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic MODE_REPACK = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORMAT_MODE   = 3'd0,
        CFG_CHANNEL_COUNT = 3'd1,
        CFG_STATUS_BYTE0  = 3'd2,
        CFG_STATUS_BYTE1  = 3'd3,
        CFG_STATUS_BYTE2  = 3'd4,
        CFG_STATUS_BYTE3  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                  mode;
        logic [COUNT_W-1:0]    count;
        logic [3:0][7:0]       status;
    } t_cfg;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [CHAN_W-1:0]  chan;
    } t_pos;

endpackage

>>> sv/iec958_subframe_formatter_top.sv
// Top level of the IEC 60958 subframe formatter.
//
// Input channel: i_in_valid / o_in_stall carry one 32-bit audio word
// (i_sample_in) per transaction. Output channel: o_out_valid / i_out_stall
// carry one formatted subframe word (o_word_out) per input transaction, in
// order. A transaction completes on a rising edge with valid high, stall low.
// A word taken into the input register moves to the result register, which
// drives o_word_out. Throughput: one transaction per cycle when not stalled;
// an input register and a result register sit either side of the formatting
// logic, so a new word is taken while a finished one still waits at the
// output. When the receiver stalls, the result holds, the input register
// fills and then o_in_stall rises until the output moves again.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data while
// no word is in flight. Sample mode advances the frame and channel counters;
// repack mode leaves them alone.
// Reset (synchronous, i_rst_n low) empties both registers, clears the frame
// and channel counters and loads repack mode, two channels, status bytes zero.
module iec958_subframe_formatter_top
    import iec958sf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [WORD_W-1:0]     i_sample_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [WORD_W-1:0]     o_word_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg              cfg;
    t_pos              pos;
    logic              r_s1_valid;
    logic [WORD_W-1:0] r_s1_sample;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic [WORD_W-1:0] n_out_word;
    logic              out_adv;
    logic              ctr_adv;

    assign out_adv    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !out_adv;
    assign ctr_adv    = r_s1_valid && out_adv && (cfg.mode == MODE_SAMPLE);

    iec958sf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    iec958sf_ctr u_ctr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (ctr_adv),
        .i_count (cfg.count),
        .o_pos   (pos)
    );

    iec958sf_fmt u_fmt (
        .i_sample (r_s1_sample),
        .i_cfg    (cfg),
        .i_pos    (pos),
        .o_word   (n_out_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_sample <= i_sample_in;
        end
        if (out_adv && r_s1_valid) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_word_out  = r_out_word;

    // the input side only backs up behind a held result
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // position moves only when a sample-mode word passes to the output
    a_pos_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ctr_adv |=> $stable(pos))
        else $error("frame/channel position changed without a word");

    a_frame_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pos.frame < FRAME_W'(BLOCK_FRAMES))
        else $error("frame index beyond block length");

    a_top_bits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_word_out[31:29] == 3'b000))
        else $error("formatted word has bits set above block start");

endmodule

>>> sv/iec958sf_cfg.sv
// Configuration register file: format mode, channel count and status bytes.
module iec958sf_cfg
    import iec958sf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FORMAT_MODE:   n_cfg.mode      = i_cfg_data[0];
                CFG_CHANNEL_COUNT: n_cfg.count     = i_cfg_data[COUNT_W-1:0];
                CFG_STATUS_BYTE0:  n_cfg.status[0] = i_cfg_data;
                CFG_STATUS_BYTE1:  n_cfg.status[1] = i_cfg_data;
                CFG_STATUS_BYTE2:  n_cfg.status[2] = i_cfg_data;
                CFG_STATUS_BYTE3:  n_cfg.status[3] = i_cfg_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= MODE_REPACK;
            r_cfg.count  <= COUNT_W'(MIN_CHANNELS);
            r_cfg.status <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/iec958sf_ctr.sv
// Frame and channel position counters within the 192-frame block.
module iec958sf_ctr
    import iec958sf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic [COUNT_W-1:0] i_count,
    output t_pos               o_pos
);

    t_pos               r_pos;
    t_pos               n_pos;
    logic [COUNT_W-1:0] count_c;
    logic [COUNT_W-1:0] chan_inc;

    always_comb begin
        // out-of-range counts clamp to the supported range
        if (i_count < COUNT_W'(MIN_CHANNELS)) begin
            count_c = COUNT_W'(MIN_CHANNELS);
        end else if (i_count > COUNT_W'(CHAN_LIMIT)) begin
            count_c = COUNT_W'(CHAN_LIMIT);
        end else begin
            count_c = i_count;
        end

        chan_inc = {1'b0, r_pos.chan} + COUNT_W'(1);
        n_pos    = r_pos;
        if (i_adv) begin
            // count lowered mid-frame: a channel already past it ends the frame
            if (chan_inc >= count_c) begin
                n_pos.chan = '0;
                if (r_pos.frame == FRAME_W'(BLOCK_FRAMES - 1)) begin
                    n_pos.frame = '0;
                end else begin
                    n_pos.frame = r_pos.frame + FRAME_W'(1);
                end
            end else begin
                n_pos.chan = chan_inc[CHAN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    assign o_pos = r_pos;

endmodule

>>> sv/iec958sf_fmt.sv
// Subframe word assembly: repack or build from sample, status bit and parity.
module iec958sf_fmt
    import iec958sf_pkg::*;
(
    input  logic [WORD_W-1:0] i_sample,
    input  t_cfg              i_cfg,
    input  t_pos              i_pos,
    output logic [WORD_W-1:0] o_word
);

    logic [7:0] cs_byte;
    logic [3:0] chan_no;
    logic       cs;
    logic       blk_start;

    always_comb begin
        chan_no = {1'b0, i_pos.chan} + 4'd1;
        cs_byte = 8'd0;
        // only frames 0..31 carry status bits
        if (i_pos.frame[7:5] == 3'd0) begin
            cs_byte = i_cfg.status[i_pos.frame[4:3]];
            if (i_pos.frame[4:3] == 2'(CFG_STATUS_BYTE2 - CFG_STATUS_BYTE0)) begin
                cs_byte[7:4] = chan_no;
            end
        end
        cs        = cs_byte[i_pos.frame[2:0]];
        blk_start = (i_pos.frame == '0) && (i_pos.chan == '0);

        if (i_cfg.mode == MODE_REPACK) begin
            // flags and audio shift down; preamble block-start lands on bit 28
            o_word = {3'b000, i_sample[3], i_sample[31:4]};
        end else begin
            o_word = {3'b000, blk_start, ^{cs, i_sample[23:0]}, cs, 2'b00,
                      i_sample[23:0]};
        end
    end

endmodule

>>> dv/tb.sv
// Self-checking testbench for the IEC 60958 subframe formatter top level.
module tb;
    import iec958sf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned TOTAL_WORDS    = 900;

    typedef struct {
        logic              set_cfg;
        t_cfg              cfg;
        logic [WORD_W-1:0] data;
        logic              known;
        logic [WORD_W-1:0] want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [WORD_W-1:0]     i_sample_in = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [WORD_W-1:0]     o_word_out;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // formatter state as the testbench sees it
    logic                cfg_mode = MODE_REPACK;
    logic [COUNT_W-1:0]  cfg_count = 4'd2;
    logic [7:0]          cfg_status [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
    logic [FRAME_W-1:0]  frm_idx = '0;
    logic [CHAN_W-1:0]   chn_idx = '0;

    logic [WORD_W-1:0] pending_words [$];
    t_row              plan [$];
    int                n_sent = 0;
    int                n_errors = 0;
    int                idle_cycles = 0;
    logic              quiet;

    // long stretch with neither side idling
    assign quiet = (n_sent >= 200) && (n_sent < 350);

    iec958_subframe_formatter_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_in (i_sample_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_word_out  (o_word_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [WORD_W-1:0] format_word(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] w;
        logic [7:0]        sb;
        logic [3:0]        lim;
        logic [CHAN_W-1:0] nxt;
        logic              cs;
        if (cfg_mode == MODE_REPACK) begin
            return {3'b000, s[3], s[31:4]};
        end
        lim = cfg_count;
        if (lim < MIN_CHANNELS) lim = COUNT_W'(MIN_CHANNELS);
        if (lim > CHAN_LIMIT) lim = COUNT_W'(CHAN_LIMIT);
        cs = 1'b0;
        if (frm_idx < 8'd32) begin
            sb = cfg_status[frm_idx[4:3]];
            // byte 2 carries the channel number, one-based
            if (frm_idx[4:3] == 2'd2) sb[7:4] = {1'b0, chn_idx} + 4'd1;
            cs = sb[frm_idx[2:0]];
        end
        w = {8'h00, s[23:0]};
        w[26] = cs;
        w[27] = ^w[26:0];
        w[28] = (frm_idx == '0) && (chn_idx == '0);
        nxt = chn_idx + 3'd1;
        if (nxt == '0 || {1'b0, nxt} >= lim) begin
            chn_idx = '0;
            frm_idx = (frm_idx == BLOCK_FRAMES - 1) ? '0 : frm_idx + 8'd1;
        end else begin
            chn_idx = nxt;
        end
        return w;
    endfunction

    function automatic t_row mk(input logic sc, input logic md, input logic [3:0] cnt,
                                input logic [31:0] st, input logic [WORD_W-1:0] d,
                                input logic kn, input logic [WORD_W-1:0] wt);
        t_row r;
        r.set_cfg     = sc;
        r.cfg.mode    = md;
        r.cfg.count   = cnt;
        r.cfg.status  = st;
        r.data        = d;
        r.known       = kn;
        r.want        = wt;
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic logic [3:0] pick_count();
        case ($urandom_range(7))
            0:       return 4'd0;
            1:       return 4'd1;
            2:       return 4'd2;
            3:       return 4'd8;
            4:       return 4'd15;
            default: return 4'($urandom_range(2, 8));
        endcase
    endfunction

    task automatic report(input string what, input logic [WORD_W-1:0] got,
                          input logic [WORD_W-1:0] want);
        $display("%0t: %s: got %08h, expected %08h", $realtime, what, got, want);
        n_errors++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        case (idx)
            CFG_FORMAT_MODE:   cfg_mode = d[0];
            CFG_CHANNEL_COUNT: cfg_count = d[COUNT_W-1:0];
            CFG_STATUS_BYTE0:  cfg_status[0] = d;
            CFG_STATUS_BYTE1:  cfg_status[1] = d;
            CFG_STATUS_BYTE2:  cfg_status[2] = d;
            CFG_STATUS_BYTE3:  cfg_status[3] = d;
            default: ;
        endcase
    endtask

    task automatic apply_cfg(input t_cfg c);
        write_reg(CFG_FORMAT_MODE, {7'b0, c.mode});
        write_reg(CFG_CHANNEL_COUNT, {4'b0, c.count});
        write_reg(CFG_STATUS_BYTE0, c.status[0]);
        write_reg(CFG_STATUS_BYTE1, c.status[1]);
        write_reg(CFG_STATUS_BYTE2, c.status[2]);
        write_reg(CFG_STATUS_BYTE3, c.status[3]);
        i_cfg_we <= 1'b0;
    endtask

    // drain: sender stops until every word in flight has come out
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic send_word(input logic [WORD_W-1:0] d, input logic kn,
                             input logic [WORD_W-1:0] wt);
        logic [WORD_W-1:0] pred;
        while (!quiet && $urandom_range(99) < 28) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= d;
        do @(posedge i_clk); while (o_in_stall);
        pred = format_word(d);
        pending_words.push_back(kn ? wt : pred);
        n_sent++;
    endtask

    // output side: random stall, compare each transaction in order
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                report("unexpected word", o_word_out, '0);
            end else begin
                logic [WORD_W-1:0] want;
                want = pending_words.pop_front();
                if (o_word_out !== want) report("word_out", o_word_out, want);
            end
        end
        i_out_stall <= !quiet && ($urandom_range(99) < 28);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_cfg rc;
        int   len;

        // reset configuration: repack mode
        plan.push_back(mk(0, MODE_REPACK, 4'd2, 32'h0, 32'h0000_0000, 1, 32'h0000_0000));
        plan.push_back(mk(0, MODE_REPACK, 4'd2, 32'h0, 32'hffff_ffff, 1, 32'h1fff_ffff));
        plan.push_back(mk(0, MODE_REPACK, 4'd2, 32'h0, 32'h0000_0008, 1, 32'h1000_0000));
        plan.push_back(mk(0, MODE_REPACK, 4'd2, 32'h0, 32'hffff_fff7, 1, 32'h0fff_ffff));
        plan.push_back(mk(0, MODE_REPACK, 4'd2, 32'h0, 32'ha5a5_a5a5, 0, '0));
        // sample mode from the start of the block
        plan.push_back(mk(1, MODE_SAMPLE, 4'd2, 32'h0, 32'h0000_0000, 1, 32'h1000_0000));
        plan.push_back(mk(0, MODE_SAMPLE, 4'd2, 32'h0, 32'h00ff_ffff, 1, 32'h00ff_ffff));
        plan.push_back(mk(0, MODE_SAMPLE, 4'd2, 32'h0, 32'hff00_0001, 1, 32'h0800_0001));
        plan.push_back(mk(0, MODE_SAMPLE, 4'd2, 32'h0, 32'h0080_0000, 0, '0));
        // eight channels, all status bits set
        plan.push_back(mk(1, MODE_SAMPLE, 4'd8, 32'hffff_ffff, 32'h0012_3456, 0, '0));
        plan.push_back(mk(0, MODE_SAMPLE, 4'd8, 32'h0, 32'hffff_ffff, 0, '0));
        plan.push_back(mk(0, MODE_SAMPLE, 4'd8, 32'h0, 32'h0000_0001, 0, '0));
        plan.push_back(mk(0, MODE_SAMPLE, 4'd8, 32'h0, 32'h8000_0000, 0, '0));
        plan.push_back(mk(0, MODE_SAMPLE, 4'd8, 32'h0, 32'h5555_5555, 0, '0));
        plan.push_back(mk(0, MODE_SAMPLE, 4'd8, 32'h0, 32'haaaa_aaaa, 0, '0));
        // count lowered below the current channel mid-frame
        plan.push_back(mk(1, MODE_SAMPLE, 4'd2, 32'h0f0f_f00f, 32'h00ab_cdef, 0, '0));
        plan.push_back(mk(0, MODE_SAMPLE, 4'd2, 32'h0, 32'h0000_0000, 0, '0));
        // counts out of range clamp to 2 and 8
        plan.push_back(mk(1, MODE_SAMPLE, 4'd0, 32'h00f0_0000, 32'h0011_1111, 0, '0));
        plan.push_back(mk(0, MODE_SAMPLE, 4'd0, 32'h0, 32'h0022_2222, 0, '0));
        plan.push_back(mk(1, MODE_SAMPLE, 4'd15, 32'hff0f_aa55, 32'h0033_3333, 0, '0));
        plan.push_back(mk(0, MODE_SAMPLE, 4'd15, 32'h0, 32'h0044_4444, 0, '0));
        plan.push_back(mk(1, MODE_SAMPLE, 4'd1, 32'h8001_8001, 32'h00ff_0000, 0, '0));
        plan.push_back(mk(1, MODE_REPACK, 4'd9, 32'h0, 32'h1234_5678, 1, 32'h1123_4567));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].set_cfg) begin
                settle();
                apply_cfg(plan[i].cfg);
            end
            send_word(plan[i].data, plan[i].known, plan[i].want);
        end

        // first random phase: two channels, long enough to wrap the block
        settle();
        rc.mode   = MODE_SAMPLE;
        rc.count  = 4'd2;
        rc.status = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        apply_cfg(rc);
        repeat (400) send_word($urandom(), 0, '0);

        while (n_sent < TOTAL_WORDS) begin
            settle();
            rc.mode   = ($urandom_range(99) < 15) ? MODE_REPACK : MODE_SAMPLE;
            rc.count  = pick_count();
            rc.status = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
            apply_cfg(rc);
            len = $urandom_range(20, 120);
            if (len > TOTAL_WORDS - n_sent) len = TOTAL_WORDS - n_sent;
            repeat (len) send_word($urandom(), 0, '0);
        end

        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            $display("%0d expected words never appeared", pending_words.size());
            n_errors += pending_words.size();
        end
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
sv/iec958sf_pkg.sv
sv/iec958sf_cfg.sv
sv/iec958sf_ctr.sv
sv/iec958sf_fmt.sv
sv/iec958_subframe_formatter_top.sv
dv/tb.sv
